FILE: rtl/trle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared types, register codes and constants for the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trle_pkg;

	// Largest encoded pixel, in bytes.
	localparam int MAX_PIXEL_BYTES_DEF = 4;

	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Packet header layout.
	localparam int     HDR_REPEAT_BIT = 7;
	localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;

	// Alpha bits for 2-byte and 4-byte pixels.
	localparam logic [31:0] ALPHA_MASK_16 = 32'h0000_8000;
	localparam logic [31:0] ALPHA_MASK_32 = 32'hff00_0000;

	// Register reset values.
	localparam logic [2:0]  RESET_PIX_BYTES       = 3'd4;
	localparam logic        RESET_INDEXED_MODE    = 1'b0;
	localparam logic [15:0] RESET_COLORMAP_ORIGIN = 16'd0;
	localparam logic [15:0] RESET_FRAME_COLS      = 16'd1;
	localparam logic [15:0] RESET_FRAME_ROWS      = 16'd1;
	localparam logic [31:0] RESET_PIXEL_TOTAL     =
		32'(RESET_FRAME_COLS) * 32'(RESET_FRAME_ROWS);

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PIX_BYTES       = 3'd0,
		REG_INDEXED_MODE    = 3'd1,
		REG_COLORMAP_ORIGIN = 3'd2,
		REG_FRAME_COLS      = 3'd3,
		REG_FRAME_ROWS      = 3'd4
	} reg_index_t;

	// Configuration register file.
	typedef struct packed {
		logic [2:0]  pix_bytes;
		logic        indexed_mode;
		logic [15:0] colormap_origin;
		logic [15:0] frame_cols;
		logic [15:0] frame_rows;
	} cfg_t;

	// One finished pixel run, passed from the front to the back.
	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  count;
		logic [2:0]  nbytes;
		logic        done;
	} pix_item_t;

endpackage

`default_nettype wire

FILE: rtl/trle_front.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder front
// Parses packet headers, assembles pixel bytes and clips runs at image end.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_front
	import trle_pkg::*;
#(
	parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       size_wr,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       q_ready,
	output logic            push,
	output pix_item_t       push_item
);

	logic        awaiting_q;
	logic        in_repeat_q;
	logic [7:0]  raw_q;
	logic [7:0]  rep_q;
	logic [1:0]  pos_q;
	logic [31:0] acc_q;
	logic [31:0] rem_q;
	logic        reload_q;

	logic [2:0]  nbytes;
	logic [2:0]  pos_inc;
	logic        complete;
	logic [31:0] acc_new;
	logic [7:0]  raw_dec;
	logic [7:0]  count_raw;
	logic [7:0]  count;
	logic        rem_zero;
	logic [31:0] rem_new;
	logic        done;
	logic [31:0] total;
	logic        take;

	assign total    = 32'(cfg.frame_cols) * 32'(cfg.frame_rows);
	assign in_ready = q_ready && !reload_q;
	assign take     = in_valid && in_ready;

	always_comb begin
		if (cfg.pix_bytes == 3'd0) begin
			nbytes = 3'd1;
		end else if (cfg.pix_bytes > 3'(MAX_PIXEL_BYTES)) begin
			nbytes = 3'(MAX_PIXEL_BYTES);
		end else begin
			nbytes = cfg.pix_bytes;
		end
	end

	assign pos_inc   = {1'b0, pos_q} + 3'd1;
	assign complete  = !(pos_inc < nbytes);
	assign acc_new   = acc_q | (32'(in_byte) << {pos_q, 3'b000});
	assign raw_dec   = (raw_q != 8'd0) ? raw_q - 8'd1 : 8'd0;
	assign count_raw = in_repeat_q ? rep_q : 8'd1;
	assign rem_zero  = (rem_q == 32'd0);

	always_comb begin
		count = count_raw;
		if (!rem_zero && ({24'd0, count_raw} > rem_q)) begin
			count = rem_q[7:0];
		end
	end

	assign rem_new = rem_q - {24'd0, count};
	assign done    = rem_zero || (rem_new == 32'd0);
	assign push    = take && !awaiting_q && complete;

	always_comb begin
		push_item.value  = acc_new;
		push_item.count  = count;
		push_item.nbytes = nbytes;
		push_item.done   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			in_repeat_q <= 1'b0;
			raw_q       <= 8'd0;
			rep_q       <= 8'd0;
			pos_q       <= 2'd0;
			acc_q       <= 32'd0;
			rem_q       <= RESET_PIXEL_TOTAL;
			reload_q    <= 1'b0;
		end else begin
			reload_q <= size_wr;
			// No byte is taken while the pixel counter reloads.
			if (reload_q) begin
				rem_q <= total;
			end else if (take) begin
				if (awaiting_q) begin
					in_repeat_q <= in_byte[HDR_REPEAT_BIT];
					if (in_byte[HDR_REPEAT_BIT]) begin
						rep_q <= (in_byte & HDR_COUNT_MASK) + 8'd1;
						raw_q <= 8'd0;
					end else begin
						raw_q <= (in_byte & HDR_COUNT_MASK) + 8'd1;
					end
					awaiting_q <= 1'b0;
					pos_q      <= 2'd0;
					acc_q      <= 32'd0;
				end else if (!complete) begin
					pos_q <= pos_inc[1:0];
					acc_q <= acc_new;
				end else begin
					pos_q <= 2'd0;
					acc_q <= 32'd0;
					// The run finished the image: start over on a fresh one.
					if (done) begin
						awaiting_q  <= 1'b1;
						in_repeat_q <= 1'b0;
						raw_q       <= 8'd0;
						rep_q       <= 8'd0;
						rem_q       <= total;
					end else begin
						if (in_repeat_q) begin
							awaiting_q  <= 1'b1;
							in_repeat_q <= 1'b0;
						end else begin
							raw_q <= raw_dec;
							if (raw_dec == 8'd0) begin
								awaiting_q <= 1'b1;
							end
						end
						rem_q <= rem_new;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/trle_queue.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder run queue
// Small register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_queue
	import trle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pix_item_t push_item,
	output logic           ready,
	input  wire logic      pop,
	output pix_item_t      pop_item,
	output logic           valid
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pix_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign ready    = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/trle_back.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder back
// Maps colormap indexes, tracks the alpha flag and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_back
	import trle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      q_valid,
	input  wire pix_item_t q_item,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [31:0]    out_value,
	output logic [7:0]     out_count,
	output logic           out_alpha,
	output logic           out_done
);

	logic        out_valid_q;
	logic [31:0] value_q;
	logic [7:0]  count_q;
	logic        alpha_out_q;
	logic        done_q;
	logic        alpha_q;

	logic [31:0] mapped;
	logic [31:0] mask;
	logic        alpha_next;

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_comb begin
		unique case (q_item.nbytes)
			3'd2:    mask = ALPHA_MASK_16;
			3'd4:    mask = ALPHA_MASK_32;
			default: mask = 32'd0;
		endcase
		if (cfg.indexed_mode) begin
			mapped     = {24'd0, q_item.value[7:0] - cfg.colormap_origin[7:0]};
			alpha_next = alpha_q;
		end else begin
			mapped     = q_item.value;
			alpha_next = alpha_q || ((q_item.value & mask) != 32'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q     <= mapped;
			count_q     <= q_item.count;
			alpha_out_q <= alpha_next;
			done_q      <= q_item.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			alpha_q     <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				// The flag starts over with each new image.
				alpha_q     <= q_item.done ? 1'b0 : alpha_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = value_q;
	assign out_count = count_q;
	assign out_alpha = alpha_out_q;
	assign out_done  = done_q;

endmodule

`default_nettype wire

FILE: rtl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes a run-length encoded TGA pixel byte stream into pixel runs.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                       Item
//  -------  ---------  ----------------------------  ---------------------------
//  s        in         s_tvalid s_tready s_tdata     one stream byte
//  m        out        m_tvalid m_tready m_tdata     one pixel run
//                      m_tuser m_tlast
//  cfg      in         cfg_valid cfg_ready           one register write
//                      cfg_index cfg_data
//
//  One byte is taken per cycle while the run queue has room and no reload is
//  under way; a run passes the run queue and then the back's output register.
//  arst_n clears all control state; the pixel counter starts at 1 x 1.
//  After a write to the image width or height, s_tready is low for one cycle
//  while the pixel counter reloads from the width times height product.
//  A stall on m holds the output register; the four-entry run queue then
//  keeps the byte side going until it fills.
//
`default_nettype none

module tga_rle_pixel_decoder
	import trle_pkg::*;
#(
	parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] data_byte

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,    // [31:0] pixel_value, [39:32] run_count
	output logic [0:0]       m_tuser,    // [0] alpha_seen
	output logic             m_tlast,    // image_done

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t      cfg_q;
	logic      cfg_wr;
	logic      size_wr;
	logic      q_ready;
	logic      q_valid;
	logic      push;
	logic      pop;
	pix_item_t push_item;
	pix_item_t pop_item;
	logic [31:0] out_value;
	logic [7:0]  out_count;
	logic        out_alpha;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign size_wr   = cfg_wr && ((cfg_index == REG_FRAME_COLS) ||
		(cfg_index == REG_FRAME_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pix_bytes       <= RESET_PIX_BYTES;
			cfg_q.indexed_mode    <= RESET_INDEXED_MODE;
			cfg_q.colormap_origin <= RESET_COLORMAP_ORIGIN;
			cfg_q.frame_cols      <= RESET_FRAME_COLS;
			cfg_q.frame_rows      <= RESET_FRAME_ROWS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_PIX_BYTES:       cfg_q.pix_bytes       <= cfg_data[2:0];
				REG_INDEXED_MODE:    cfg_q.indexed_mode    <= cfg_data[0];
				REG_COLORMAP_ORIGIN: cfg_q.colormap_origin <= cfg_data;
				REG_FRAME_COLS:      cfg_q.frame_cols      <= cfg_data;
				REG_FRAME_ROWS:      cfg_q.frame_rows      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: header parsing, byte assembly and clipping at the image end.
	trle_front #(
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.size_wr  (size_wr),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_ready  (q_ready),
		.push     (push),
		.push_item(push_item)
	);

	trle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.ready    (q_ready),
		.pop      (pop),
		.pop_item (pop_item),
		.valid    (q_valid)
	);

	// Back: index mapping, alpha tracking and the output register.
	trle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (pop_item),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_value(out_value),
		.out_count(out_count),
		.out_alpha(out_alpha),
		.out_done (m_tlast)
	);

	assign m_tdata = {out_count, out_value};
	assign m_tuser = out_alpha;

endmodule

`default_nettype wire

FILE: rtl/trle_checker.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder port checker
// Watches the decoder ports over time and flags broken behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_checker
	import trle_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [0:0]  m_tuser,
	input wire logic        m_tlast,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [2:0]  cfg_index
);

	// A stalled run keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("output run changed while stalled");

	// Every run covers between one and 128 pixels.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
		else $error("run count out of range");

	// A size write holds off the byte stream while the pixel counter reloads.
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready &&
		((cfg_index == REG_FRAME_COLS) || (cfg_index == REG_FRAME_ROWS))
		|=> !s_tready)
		else $error("byte taken during pixel counter reload");

	// The configuration port never stalls.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind tga_rle_pixel_decoder trle_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_index(cfg_index)
);

`default_nettype wire
